@@ hw/rtl/lzsd_pkg.sv @@
// ----------------------------------------------------------------------------
// LZ77 stream decompressor package
// Shared widths, result status codes and the command and status structs
// that pass between the token parser and the output unit.
// ----------------------------------------------------------------------------
package lzsd_pkg;

   localparam int BYTE_W     = 8;
   localparam int DISP_W     = 12;
   localparam int LEN_W      = 5;
   localparam int HDR_SIZE_W = 24;
   localparam int STATUS_W   = 2;
   localparam int TYPE_W     = 3;
   localparam int FLAG_CNT_W = 4;

   localparam logic [TYPE_W-1:0]     LZ77_TYPE  = 3'd1;
   localparam logic [LEN_W-1:0]      LEN_BIAS   = 5'd3;
   localparam logic [FLAG_CNT_W-1:0] FLAG_TOKENS = 4'd8;

   localparam logic [STATUS_W-1:0] ST_DATA     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_TYPE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_REF  = 2'd2;

   typedef enum logic [1:0] {
      CMD_LIT,
      CMD_COPY,
      CMD_ERR_TYPE,
      CMD_ERR_REF
   } cmd_kind_type;

   typedef struct packed {
      logic                valid;
      logic                clear;
      cmd_kind_type        kind;
      logic [BYTE_W-1:0]   data;
      logic [DISP_W-1:0]   disp;
      logic [LEN_W-1:0]    len;
   } emit_cmd_type;

   typedef struct packed {
      logic idle;
      logic slot_free;
   } emit_status_type;

endpackage

@@ hw/rtl/lz77_stream_decompressor_top.sv @@
// ----------------------------------------------------------------------------
// LZ77 stream decompressor
// Parses a type 1 LZ77 stream one compressed byte per transfer and sends
// the decompressed bytes, and one error result if bad, on the result channel.
//
//   Channel   Ports   Direction   Payload
//   request   req_    in          in_byte, stream_start
//   response  rsp_    out         out_byte, status, final_res
//
// Header, flag, literal and first reference bytes are handled as they are
// accepted. The second reference byte copies n bytes (3 to 18) through the
// single registered read port of the history RAM, one byte per cycle while
// the response channel is free, and takes no new request until it is done.
// Reset is synchronous and does not clear the history RAM.
// A stall on the response channel freezes the copy loop and holds requests.
// ----------------------------------------------------------------------------
module lz77_stream_decompressor_top import lzsd_pkg::*; #(
   parameter int WINDOW_DEPTH = 4096,
   parameter int SIZE_BITS    = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [BYTE_W-1:0]    req_in_byte,
   input  logic                 req_stream_start,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [BYTE_W-1:0]    rsp_out_byte,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic                 rsp_final_res
);

   localparam int CMP_W = (SIZE_BITS > DISP_W) ? SIZE_BITS : DISP_W;
   localparam int SUM_W = SIZE_BITS + 1;

   typedef enum logic [5:0] {
      PH_IDLE      = 6'b000001,
      PH_HEADER    = 6'b000010,
      PH_FLAG      = 6'b000100,
      PH_TOKEN     = 6'b001000,
      PH_TOKEN_LOW = 6'b010000,
      PH_DONE      = 6'b100000
   } phase_type;

   phase_type                 phase_ff, phase_in;
   logic [1:0]                hdr_idx_ff, hdr_idx_in;
   logic [HDR_SIZE_W-1:0]     size_ff, size_in;
   logic [BYTE_W-1:0]         flag_bits_ff, flag_bits_in;
   logic [FLAG_CNT_W-1:0]     flag_cnt_ff, flag_cnt_in;
   logic [BYTE_W-1:0]         token_high_ff, token_high_in;

   phase_type                 cur_phase;
   logic [1:0]                idx_b;
   logic [HDR_SIZE_W-1:0]     size_b;
   logic [HDR_SIZE_W-1:0]     size_new;
   logic [BYTE_W-1:0]         flags_b;
   logic [FLAG_CNT_W-1:0]     cnt_b;
   logic [FLAG_CNT_W-1:0]     cnt_next;
   logic [BYTE_W-1:0]         high_b;
   logic [DISP_W-1:0]         disp;
   logic [LEN_W-1:0]          len;
   logic [LEN_W-1:0]          step;
   logic                      reach_end;
   logic                      ref_bad;
   logic                      req_accept;
   logic [SIZE_BITS-1:0]      target;
   logic [SIZE_BITS-1:0]      produced;
   emit_cmd_type              cmd;
   emit_status_type           emit_st;

   assign req_ready  = emit_st.idle && emit_st.slot_free;
   assign req_accept = req_valid && req_ready;
   assign target     = size_ff[SIZE_BITS-1:0];

   assign cur_phase = req_stream_start ? PH_HEADER : phase_ff;
   assign idx_b     = req_stream_start ? 2'd0 : hdr_idx_ff;
   assign size_b    = req_stream_start ? '0 : size_ff;
   assign flags_b   = req_stream_start ? '0 : flag_bits_ff;
   assign cnt_b     = req_stream_start ? '0 : flag_cnt_ff;
   assign high_b    = req_stream_start ? '0 : token_high_ff;

   assign disp      = {high_b[3:0], req_in_byte};
   assign len       = LEN_BIAS + LEN_W'(high_b[7:4]);
   assign step      = (cur_phase == PH_TOKEN_LOW) ? len : LEN_W'(1);
   assign reach_end = (SUM_W'(produced) + SUM_W'(step)) >= SUM_W'(target);
   assign ref_bad   = CMP_W'(disp) >= CMP_W'(produced);
   assign cnt_next  = cnt_b - FLAG_CNT_W'(1);

   always_comb begin
      size_new = size_b;
      if (idx_b != 2'd0) begin
         size_new[BYTE_W*(int'(idx_b) - 1) +: BYTE_W] = req_in_byte;
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      hdr_idx_in    = hdr_idx_ff;
      size_in       = size_ff;
      flag_bits_in  = flag_bits_ff;
      flag_cnt_in   = flag_cnt_ff;
      token_high_in = token_high_ff;
      cmd           = '0;
      cmd.data      = req_in_byte;
      cmd.disp      = disp;
      cmd.len       = len;

      if (req_accept) begin
         cmd.clear     = req_stream_start;
         hdr_idx_in    = idx_b;
         size_in       = size_b;
         flag_bits_in  = flags_b;
         flag_cnt_in   = cnt_b;
         token_high_in = high_b;
         phase_in      = cur_phase;

         case (cur_phase)
            PH_HEADER: begin
               if (idx_b == 2'd0) begin
                  if (req_in_byte[6:4] != LZ77_TYPE) begin
                     cmd.valid = 1'b1;
                     cmd.kind  = CMD_ERR_TYPE;
                     phase_in  = PH_DONE;
                  end else begin
                     hdr_idx_in = 2'd1;
                  end
               end else begin
                  size_in = size_new;
                  if (idx_b == 2'd3) begin
                     hdr_idx_in = 2'd0;
                     phase_in   = (size_new[SIZE_BITS-1:0] == '0) ? PH_DONE : PH_FLAG;
                  end else begin
                     hdr_idx_in = idx_b + 2'd1;
                  end
               end
            end
            PH_FLAG: begin
               flag_bits_in = req_in_byte;
               flag_cnt_in  = FLAG_TOKENS;
               phase_in     = PH_TOKEN;
            end
            PH_TOKEN: begin
               if (flags_b[BYTE_W-1]) begin
                  token_high_in = req_in_byte;
                  phase_in      = PH_TOKEN_LOW;
               end else begin
                  cmd.valid    = 1'b1;
                  cmd.kind     = CMD_LIT;
                  flag_bits_in = {flags_b[BYTE_W-2:0], 1'b0};
                  flag_cnt_in  = cnt_next;
                  if (reach_end) begin
                     phase_in = PH_DONE;
                  end else begin
                     phase_in = (cnt_next == '0) ? PH_FLAG : PH_TOKEN;
                  end
               end
            end
            PH_TOKEN_LOW: begin
               cmd.valid = 1'b1;
               if (ref_bad) begin
                  cmd.kind = CMD_ERR_REF;
                  phase_in = PH_DONE;
               end else begin
                  cmd.kind     = CMD_COPY;
                  flag_bits_in = {flags_b[BYTE_W-2:0], 1'b0};
                  flag_cnt_in  = cnt_next;
                  if (reach_end) begin
                     phase_in = PH_DONE;
                  end else begin
                     phase_in = (cnt_next == '0) ? PH_FLAG : PH_TOKEN;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         hdr_idx_ff    <= '0;
         size_ff       <= '0;
         flag_bits_ff  <= '0;
         flag_cnt_ff   <= '0;
         token_high_ff <= '0;
      end else begin
         phase_ff      <= phase_in;
         hdr_idx_ff    <= hdr_idx_in;
         size_ff       <= size_in;
         flag_bits_ff  <= flag_bits_in;
         flag_cnt_ff   <= flag_cnt_in;
         token_high_ff <= token_high_in;
      end
   end

   lzsd_emit #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .SIZE_BITS    (SIZE_BITS)
   ) u_emit (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .target        (target),
      .produced      (produced),
      .status        (emit_st),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_status    (rsp_status),
      .rsp_final_res (rsp_final_res)
   );

endmodule

@@ hw/rtl/lzsd_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered and holds
// while the read enable is low.
// ----------------------------------------------------------------------------
module lzsd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/lzsd_emit.sv @@
// ----------------------------------------------------------------------------
// LZ77 output unit
// Owns the history RAM, the write position, the output count and the
// result register. Literals and error results are written to it directly;
// a back-reference runs a read-ahead copy loop, one byte per unstalled cycle.
// ----------------------------------------------------------------------------
module lzsd_emit import lzsd_pkg::*; #(
   parameter int WINDOW_DEPTH = 4096,
   parameter int SIZE_BITS    = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  emit_cmd_type          cmd,
   input  logic [SIZE_BITS-1:0]  target,
   output logic [SIZE_BITS-1:0]  produced,
   output emit_status_type       status,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [BYTE_W-1:0]     rsp_out_byte,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic                  rsp_final_res
);

   localparam int WIN_BITS = $clog2(WINDOW_DEPTH);

   typedef enum logic [1:0] {
      E_IDLE = 2'b01,
      E_COPY = 2'b10
   } emit_state_type;

   emit_state_type        state_ff, state_in;
   logic [WIN_BITS-1:0]   wp_ff, wp_in;
   logic [SIZE_BITS-1:0]  produced_ff, produced_in;
   logic [WIN_BITS-1:0]   src_ff, src_in;
   logic [LEN_W-1:0]      left_ff, left_in;
   logic                  pend_ff, pend_in;
   logic                  fwd_ff, fwd_in;
   logic [BYTE_W-1:0]     fwd_byte_ff, fwd_byte_in;
   logic                  out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]     out_byte_ff, out_byte_in;
   logic [STATUS_W-1:0]   out_status_ff, out_status_in;
   logic                  out_final_ff, out_final_in;

   logic                  slot_free;
   logic [BYTE_W-1:0]     ram_rd_data;
   logic [BYTE_W-1:0]     copy_byte;
   logic                  emit_now;
   logic                  lit_now;
   logic                  last_emit;
   logic                  issue_now;
   logic [LEN_W-1:0]      unissued;
   logic [SIZE_BITS-1:0]  prod_next;
   logic                  is_final;
   logic                  wr_en;
   logic [BYTE_W-1:0]     wr_byte;

   assign slot_free = !out_valid_ff || rsp_ready;
   assign copy_byte = fwd_ff ? fwd_byte_ff : ram_rd_data;
   assign prod_next = produced_ff + SIZE_BITS'(1);
   assign is_final  = (prod_next == target);
   assign emit_now  = (state_ff == E_COPY) && pend_ff && slot_free;
   assign lit_now   = (state_ff == E_IDLE) && cmd.valid && (cmd.kind == CMD_LIT);
   assign last_emit = emit_now && ((left_ff == LEN_W'(1)) || is_final);
   assign unissued  = left_ff - LEN_W'(pend_ff);
   assign issue_now = (state_ff == E_COPY) && !(pend_ff && !emit_now)
                      && (unissued != '0) && !last_emit;
   assign wr_en     = emit_now || lit_now;
   assign wr_byte   = emit_now ? copy_byte : cmd.data;

   lzsd_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (WINDOW_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wp_ff),
      .wr_data (wr_byte),
      .rd_en   (issue_now),
      .rd_addr (src_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      wp_in         = wp_ff;
      produced_in   = produced_ff;
      src_in        = src_ff;
      left_in       = left_ff;
      pend_in       = pend_ff;
      fwd_in        = fwd_ff;
      fwd_byte_in   = fwd_byte_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_byte_in   = out_byte_ff;
      out_status_in = out_status_ff;
      out_final_in  = out_final_ff;

      if (cmd.clear) begin
         wp_in       = '0;
         produced_in = '0;
      end

      case (state_ff)
         E_IDLE: begin
            if (cmd.valid) begin
               case (cmd.kind)
                  CMD_LIT: begin
                     wp_in         = wp_ff + WIN_BITS'(1);
                     produced_in   = prod_next;
                     out_valid_in  = 1'b1;
                     out_byte_in   = cmd.data;
                     out_status_in = ST_DATA;
                     out_final_in  = is_final;
                  end
                  CMD_COPY: begin
                     src_in   = wp_ff - WIN_BITS'(cmd.disp) - WIN_BITS'(1);
                     left_in  = cmd.len;
                     pend_in  = 1'b0;
                     state_in = E_COPY;
                  end
                  CMD_ERR_TYPE: begin
                     out_valid_in  = 1'b1;
                     out_byte_in   = '0;
                     out_status_in = ST_BAD_TYPE;
                     out_final_in  = 1'b1;
                  end
                  CMD_ERR_REF: begin
                     out_valid_in  = 1'b1;
                     out_byte_in   = '0;
                     out_status_in = ST_BAD_REF;
                     out_final_in  = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         E_COPY: begin
            if (emit_now) begin
               wp_in         = wp_ff + WIN_BITS'(1);
               produced_in   = prod_next;
               left_in       = left_ff - LEN_W'(1);
               out_valid_in  = 1'b1;
               out_byte_in   = copy_byte;
               out_status_in = ST_DATA;
               out_final_in  = is_final;
            end
            pend_in = issue_now || (pend_ff && !emit_now);
            if (issue_now) begin
               // A read of the entry written in this very cycle takes the
               // written byte directly, since the RAM returns the old one.
               src_in      = src_ff + WIN_BITS'(1);
               fwd_in      = emit_now && (src_ff == wp_ff);
               fwd_byte_in = copy_byte;
            end
            if (last_emit) begin
               state_in = E_IDLE;
            end
         end
         default: begin
            state_in = E_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= E_IDLE;
         wp_ff        <= '0;
         produced_ff  <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         produced_ff  <= produced_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff        <= src_in;
      left_ff       <= left_in;
      fwd_ff        <= fwd_in;
      fwd_byte_ff   <= fwd_byte_in;
      out_byte_ff   <= out_byte_in;
      out_status_ff <= out_status_in;
      out_final_ff  <= out_final_in;
   end

   assign produced         = produced_ff;
   assign status.idle      = (state_ff == E_IDLE);
   assign status.slot_free = slot_free;
   assign rsp_valid        = out_valid_ff;
   assign rsp_out_byte     = out_byte_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_final_res    = out_final_ff;

endmodule

@@ hw/rtl/lzsd_checker.sv @@
// ----------------------------------------------------------------------------
// LZ77 stream decompressor port checker
// Concurrent checks on what the top level shows at its ports, attached to
// the top level by a bind statement.
// ----------------------------------------------------------------------------
module lzsd_checker import lzsd_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [BYTE_W-1:0]    rsp_out_byte,
   input logic [STATUS_W-1:0]  rsp_status,
   input logic                 rsp_final_res
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_status) && $stable(rsp_final_res))
      else $error("Response changed while stalled.");

   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_DATA) |-> (rsp_out_byte == '0) && rsp_final_res)
      else $error("Error result is not a zero final byte.");

   a_no_req_when_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("Request taken while a result is stalled.");

   a_quiet_after_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_final_res && !(req_valid && req_ready)
         |=> !rsp_valid)
      else $error("Result after the final transfer without a new request.");

endmodule

bind lz77_stream_decompressor_top lzsd_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_out_byte  (rsp_out_byte),
   .rsp_status    (rsp_status),
   .rsp_final_res (rsp_final_res)
);
